>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro expects clk_i and rst_ni
// to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Invariant that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  `ASSERT_CLK(lbl, (expr), msg)

`endif

>>> rtl/sws_pkg.sv
package sws_pkg;

  // Sample and statistics width (unsigned, 8 fraction bits).
  localparam int unsigned SMP_W = 24;
  // Recent sum width and its saturation value.
  localparam int unsigned RS_W = 31;
  localparam logic [RS_W-1:0] RS_MAX = {RS_W{1'b1}};

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECENT = 1'b1;
  localparam logic [CFG_DATA_W-1:0] RECENT_RESET = 8'd60;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_RCT,
    ST_UPD,
    ST_SCAN,
    ST_DIVLD,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

>>> rtl/sws_if.sv
// Input channel: one sample or clear command per beat.
interface sws_in_if;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [sws_pkg::SMP_W-1:0] sample;

  modport source (output valid, mode, sample, input ready);
  modport sink   (input valid, mode, sample, output ready);
endinterface

// Output channel: one set of statistics per beat.
interface sws_out_if;
  logic                     valid;
  logic                     ready;
  logic                     updated;
  logic [sws_pkg::SMP_W-1:0] window_average;
  logic [sws_pkg::SMP_W-1:0] recent_average;
  logic [sws_pkg::SMP_W-1:0] window_min;
  logic [sws_pkg::SMP_W-1:0] window_max;

  modport source (output valid, updated, window_average, recent_average, window_min,
                  window_max, input ready);
  modport sink   (input valid, updated, window_average, recent_average, window_min,
                  window_max, output ready);
endinterface

>>> rtl/sliding_window_stats.sv
// Sliding-window statistics over one unsigned measurement (24 bits, 8 fraction
// bits). The last WINDOW samples sit in a ring memory with one write port and
// a registered read port. WINDOW is a power of two. Each input beat either
// adds a sample (mode 0; while paused the sample is dropped and the beat is
// marked not updated) or clears the window sum, minimum, maximum and ring
// entries (mode 1; the recent sum is kept), and yields exactly one output beat
// carrying the window average, the recent average over the newest recent_count
// samples, and the window minimum and maximum. One item is processed at a
// time; input ready is high only while the block is idle, but a finished
// result waits in an output register so the next item can be taken before it
// is consumed. A sample that retires the current minimum or maximum also
// rescans the memory, reading one entry per cycle, and a clear sweeps the
// memory, writing one entry per cycle. Every item passes the bit-serial
// divider for the recent average, which yields one quotient bit per cycle
// over the RS_W (31) bits of the recent sum. The window average is the window
// sum shifted right by log2 WINDOW and costs no time. After reset a clearing
// pass writes zero to every entry, during which no input beat is accepted;
// configuration writes are taken at any time.

`include "assert_macros.svh"

module sliding_window_stats #(
  parameter int unsigned WINDOW = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sws_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sws_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  sws_in_if.sink                            in_i,
  sws_out_if.source                         out_o
);

  localparam int unsigned SMP_W = sws_pkg::SMP_W;
  localparam int unsigned RS_W  = sws_pkg::RS_W;
  // Ring address, and a counter one bit wider so that it can hold WINDOW.
  localparam int unsigned AW    = $clog2(WINDOW);
  localparam int unsigned PW    = AW + 1;
  // Divisor width: the recent count is at most WINDOW.
  localparam int unsigned DIV_W = $clog2(WINDOW + 1);
  // The window sum is exact and never exceeds WINDOW * (2^SMP_W - 1).
  localparam int unsigned WS_W  = SMP_W + AW;
  localparam int unsigned DVD_W = RS_W;
  localparam int unsigned DC_W  = $clog2(DVD_W);

  // Ring memory.
  logic [SMP_W-1:0] ring_q [WINDOW];
  logic [SMP_W-1:0] rd_data_q;
  logic             mem_we;
  logic             mem_re;
  logic [AW-1:0]    mem_waddr;
  logic [AW-1:0]    mem_raddr;
  logic [SMP_W-1:0] mem_wdata;

  // Control and statistics state.
  sws_pkg::state_e  state_q, state_d;
  logic [PW-1:0]    cnt_q, cnt_d;
  logic             scan_vld_q, scan_vld_d;
  logic             clr_item_q, clr_item_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic [WS_W-1:0]  ws_q, ws_d;
  logic [RS_W-1:0]  rs_q, rs_d;
  logic [SMP_W-1:0] cur_min_q, cur_min_d;
  logic [SMP_W-1:0] cur_max_q, cur_max_d;
  logic [SMP_W-1:0] scan_min_q, scan_min_d;
  logic [SMP_W-1:0] scan_max_q, scan_max_d;
  logic [SMP_W-1:0] smp_q, smp_d;
  logic [SMP_W-1:0] old_q, old_d;
  logic             upd_q, upd_d;

  // Configuration registers.
  logic                           pause_q, pause_d;
  logic [sws_pkg::CFG_DATA_W-1:0] rcount_q, rcount_d;

  // Bit-serial restoring divider for the recent average.
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DIV_W:0]   rem_q, rem_d;
  logic [DIV_W-1:0] dvs_q, dvs_d;
  logic [DC_W-1:0]  dcnt_q, dcnt_d;
  logic [SMP_W-1:0] ravg_q, ravg_d;

  // Output register.
  logic             out_vld_q, out_vld_d;
  logic             o_upd_q, o_upd_d;
  logic [SMP_W-1:0] o_wavg_q, o_wavg_d;
  logic [SMP_W-1:0] o_ravg_q, o_ravg_d;
  logic [SMP_W-1:0] o_min_q, o_min_d;
  logic [SMP_W-1:0] o_max_q, o_max_d;

  // Helpers.
  logic [DIV_W-1:0] eff_n;
  logic [PW-1:0]    p_ext;
  logic [PW-1:0]    n_ext;
  logic [PW-1:0]    ridx_ext;
  logic [RS_W-1:0]  rs_sub;
  logic [RS_W:0]    rs_add;
  logic [DIV_W:0]   rem_sh;
  logic             rem_ge;
  logic [DVD_W-1:0] dvd_next;

  // The effective recent count: zero acts as one, anything above WINDOW
  // is clipped to WINDOW.
  always_comb begin
    if (rcount_q == '0) begin
      eff_n = DIV_W'(1);
    end else if (int'(rcount_q) > int'(WINDOW)) begin
      eff_n = DIV_W'(WINDOW);
    end else begin
      eff_n = DIV_W'(rcount_q);
    end
  end

  // Entry that falls out of the recent span: (ptr - n) modulo WINDOW.
  assign p_ext    = {1'b0, ptr_q};
  assign n_ext    = PW'(eff_n);
  assign ridx_ext = (p_ext >= n_ext) ? (p_ext - n_ext) : (p_ext + PW'(WINDOW) - n_ext);

  // Recent sum update: saturating subtract of the retired recent sample,
  // then saturating add of the new one. rd_data_q holds that sample in ST_UPD.
  assign rs_sub = (rs_q >= RS_W'(rd_data_q)) ? (rs_q - RS_W'(rd_data_q)) : '0;
  assign rs_add = {1'b0, rs_sub} + (RS_W + 1)'(smp_q);

  // One divider step: shift in the next dividend bit and subtract if it fits.
  assign rem_sh   = {rem_q[DIV_W-1:0], dvd_q[DVD_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, dvs_q});
  assign dvd_next = {dvd_q[DVD_W-2:0], rem_ge};

  assign in_i.ready           = (state_q == sws_pkg::ST_IDLE);
  assign out_o.valid          = out_vld_q;
  assign out_o.updated        = o_upd_q;
  assign out_o.window_average = o_wavg_q;
  assign out_o.recent_average = o_ravg_q;
  assign out_o.window_min     = o_min_q;
  assign out_o.window_max     = o_max_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    scan_vld_d = scan_vld_q;
    clr_item_d = clr_item_q;
    ptr_d      = ptr_q;
    ws_d       = ws_q;
    rs_d       = rs_q;
    cur_min_d  = cur_min_q;
    cur_max_d  = cur_max_q;
    scan_min_d = scan_min_q;
    scan_max_d = scan_max_q;
    smp_d      = smp_q;
    old_d      = old_q;
    upd_d      = upd_q;
    pause_d    = pause_q;
    rcount_d   = rcount_q;
    dvd_d      = dvd_q;
    rem_d      = rem_q;
    dvs_d      = dvs_q;
    dcnt_d     = dcnt_q;
    ravg_d     = ravg_q;
    out_vld_d  = out_vld_q;
    o_upd_d    = o_upd_q;
    o_wavg_d   = o_wavg_q;
    o_ravg_d   = o_ravg_q;
    o_min_d    = o_min_q;
    o_max_d    = o_max_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = ptr_q;
    mem_raddr  = ptr_q;
    mem_wdata  = smp_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        sws_pkg::CFG_PAUSE:  pause_d  = cfg_data_i[0];
        sws_pkg::CFG_RECENT: rcount_d = cfg_data_i;
        default: ;
      endcase
    end

    if (out_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      sws_pkg::ST_CLEAR: begin
        // Zero one ring entry per cycle.
        mem_we    = 1'b1;
        mem_waddr = cnt_q[AW-1:0];
        mem_wdata = '0;
        cnt_d     = cnt_q + PW'(1);
        if (cnt_q == PW'(WINDOW - 1)) begin
          cnt_d = '0;
          if (clr_item_q) begin
            state_d = sws_pkg::ST_DIVLD;
          end else begin
            state_d = sws_pkg::ST_IDLE;
          end
        end
      end

      sws_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          smp_d      = in_i.sample;
          // Fetch the oldest entry straight away; it is unused on other paths.
          mem_re     = 1'b1;
          mem_raddr  = ptr_q;
          if (in_i.mode == sws_pkg::MODE_CLEAR) begin
            clr_item_d = 1'b1;
            cnt_d      = '0;
            ws_d       = '0;
            cur_min_d  = '0;
            cur_max_d  = '0;
            upd_d      = 1'b1;
            state_d    = sws_pkg::ST_CLEAR;
          end else if (pause_q) begin
            upd_d   = 1'b0;
            state_d = sws_pkg::ST_DIVLD;
          end else begin
            upd_d   = 1'b1;
            state_d = sws_pkg::ST_RD_RCT;
          end
        end
      end

      sws_pkg::ST_RD_RCT: begin
        old_d     = rd_data_q;
        mem_re    = 1'b1;
        mem_raddr = ridx_ext[AW-1:0];
        state_d   = sws_pkg::ST_UPD;
      end

      sws_pkg::ST_UPD: begin
        ws_d = ws_q - WS_W'(old_q) + WS_W'(smp_q);
        if (rs_add > (RS_W + 1)'(sws_pkg::RS_MAX)) begin
          rs_d = sws_pkg::RS_MAX;
        end else begin
          rs_d = rs_add[RS_W-1:0];
        end
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = smp_q;
        ptr_d     = (ptr_q == AW'(WINDOW - 1)) ? '0 : (ptr_q + AW'(1));
        if ((old_q == cur_min_q) || (old_q == cur_max_q)) begin
          // The retired sample was an extreme: rebuild both from the ring.
          scan_min_d = '1;
          scan_max_d = '0;
          scan_vld_d = 1'b0;
          cnt_d      = '0;
          state_d    = sws_pkg::ST_SCAN;
        end else begin
          cur_min_d = (smp_q < cur_min_q) ? smp_q : cur_min_q;
          cur_max_d = (smp_q > cur_max_q) ? smp_q : cur_max_q;
          state_d   = sws_pkg::ST_DIVLD;
        end
      end

      sws_pkg::ST_SCAN: begin
        // Each read is compared in the cycle after it is issued.
        if (cnt_q != PW'(WINDOW)) begin
          mem_re    = 1'b1;
          mem_raddr = cnt_q[AW-1:0];
          cnt_d     = cnt_q + PW'(1);
        end
        scan_vld_d = (cnt_q != PW'(WINDOW));
        if (scan_vld_q) begin
          scan_min_d = (rd_data_q < scan_min_q) ? rd_data_q : scan_min_q;
          scan_max_d = (rd_data_q > scan_max_q) ? rd_data_q : scan_max_q;
        end
        if ((cnt_q == PW'(WINDOW)) && !scan_vld_q) begin
          cur_min_d = (smp_q < scan_min_q) ? smp_q : scan_min_q;
          cur_max_d = (smp_q > scan_max_q) ? smp_q : scan_max_q;
          cnt_d     = '0;
          state_d   = sws_pkg::ST_DIVLD;
        end
      end

      sws_pkg::ST_DIVLD: begin
        dvd_d   = DVD_W'(rs_q);
        dvs_d   = eff_n;
        rem_d   = '0;
        dcnt_d  = '0;
        state_d = sws_pkg::ST_DIV;
      end

      sws_pkg::ST_DIV: begin
        rem_d  = rem_ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
        dvd_d  = dvd_next;
        dcnt_d = dcnt_q + DC_W'(1);
        if (dcnt_q == DC_W'(DVD_W - 1)) begin
          if (|dvd_next[DVD_W-1:SMP_W]) begin
            ravg_d = '1;
          end else begin
            ravg_d = dvd_next[SMP_W-1:0];
          end
          state_d = sws_pkg::ST_DONE;
        end
      end

      sws_pkg::ST_DONE: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d  = 1'b1;
          o_upd_d    = upd_q;
          o_wavg_d   = ws_q[WS_W-1:AW];
          o_ravg_d   = ravg_q;
          o_min_d    = cur_min_q;
          o_max_d    = cur_max_q;
          clr_item_d = 1'b0;
          state_d    = sws_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = sws_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sws_pkg::ST_CLEAR;
      cnt_q      <= '0;
      scan_vld_q <= 1'b0;
      clr_item_q <= 1'b0;
      ptr_q      <= '0;
      ws_q       <= '0;
      rs_q       <= '0;
      cur_min_q  <= '0;
      cur_max_q  <= '0;
      upd_q      <= 1'b0;
      pause_q    <= 1'b0;
      rcount_q   <= sws_pkg::RECENT_RESET;
      dcnt_q     <= '0;
      rem_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      scan_vld_q <= scan_vld_d;
      clr_item_q <= clr_item_d;
      ptr_q      <= ptr_d;
      ws_q       <= ws_d;
      rs_q       <= rs_d;
      cur_min_q  <= cur_min_d;
      cur_max_q  <= cur_max_d;
      upd_q      <= upd_d;
      pause_q    <= pause_d;
      rcount_q   <= rcount_d;
      dcnt_q     <= dcnt_d;
      rem_q      <= rem_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    scan_min_q <= scan_min_d;
    scan_max_q <= scan_max_d;
    smp_q      <= smp_d;
    old_q      <= old_d;
    dvd_q      <= dvd_d;
    dvs_q      <= dvs_d;
    ravg_q     <= ravg_d;
    o_upd_q    <= o_upd_d;
    o_wavg_q   <= o_wavg_d;
    o_ravg_q   <= o_ravg_d;
    o_min_q    <= o_min_d;
    o_max_q    <= o_max_d;
  end

  // Ring memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= ring_q[mem_raddr];
    end
  end

  `ASSERT_CLK(a_accept_leaves_idle, (in_i.valid && in_i.ready) |=> (state_q != sws_pkg::ST_IDLE), "accepted beat did not start processing")
  `ASSERT_CLK(a_rem_below_divisor, (state_q == sws_pkg::ST_DIV) |-> (rem_q < {1'b0, dvs_q}), "divider remainder not below divisor")
  `ASSERT_CLK(a_result_from_done, $rose(out_vld_q) |-> $past(state_q == sws_pkg::ST_DONE), "result raised outside the finishing state")
  `ASSERT_ALWAYS(a_min_le_max, cur_min_q <= cur_max_q, "window minimum above window maximum")

endmodule
